// ----- hdl/assert_macros.svh -----
// assertion macros used by the morse encoder top level
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define MTE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mte assertion failed");

// next-cycle implication, checked out of reset
`define MTE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mte assertion failed");

`endif

// ----- hdl/mte_pkg.sv -----
`timescale 1ns / 1ps
// shared types, symbol codes and the morse code table for the encoder
// no dependencies

package mte_pkg;

  localparam int CHAR_W = 8;
  localparam int SYM_W  = 2;
  localparam int PAT_W  = 6;   // longest code
  localparam int LEN_W  = 3;   // holds 0..6
  localparam int CNT_W  = 3;   // holds 0..7 symbols per word
  localparam int BUF_W  = SYM_W * (PAT_W + 1);

  localparam logic [SYM_W-1:0] SYM_DOT     = 2'd0;
  localparam logic [SYM_W-1:0] SYM_DASH    = 2'd1;
  localparam logic [SYM_W-1:0] SYM_SPACE   = 2'd2;
  localparam logic [SYM_W-1:0] SYM_NEWLINE = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

  // pat is left aligned: pat[PAT_W-1] is the first symbol, 1 means dash
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] pat;
  } code_t;

  // word waiting in front of the serializer
  typedef struct packed {
    logic  nl;
    logic  owed;
    code_t code;
  } pend_t;

  function automatic code_t code_lookup(input logic [CHAR_W-1:0] ch);
    code_t r;
    case (ch)
      8'h41: r = '{3'd2, 6'b010000};  // A
      8'h42: r = '{3'd4, 6'b100000};  // B
      8'h43: r = '{3'd4, 6'b101000};  // C
      8'h44: r = '{3'd3, 6'b100000};  // D
      8'h45: r = '{3'd1, 6'b000000};  // E
      8'h46: r = '{3'd4, 6'b001000};  // F
      8'h47: r = '{3'd3, 6'b110000};  // G
      8'h48: r = '{3'd4, 6'b000000};  // H
      8'h49: r = '{3'd2, 6'b000000};  // I
      8'h4a: r = '{3'd4, 6'b011100};  // J
      8'h4b: r = '{3'd3, 6'b101000};  // K
      8'h4c: r = '{3'd4, 6'b010000};  // L
      8'h4d: r = '{3'd2, 6'b110000};  // M
      8'h4e: r = '{3'd2, 6'b100000};  // N
      8'h4f: r = '{3'd3, 6'b111000};  // O
      8'h50: r = '{3'd4, 6'b011000};  // P
      8'h51: r = '{3'd4, 6'b110100};  // Q
      8'h52: r = '{3'd3, 6'b010000};  // R
      8'h53: r = '{3'd3, 6'b000000};  // S
      8'h54: r = '{3'd1, 6'b100000};  // T
      8'h55: r = '{3'd3, 6'b001000};  // U
      8'h56: r = '{3'd4, 6'b000100};  // V
      8'h57: r = '{3'd3, 6'b011000};  // W
      8'h58: r = '{3'd4, 6'b100100};  // X
      8'h59: r = '{3'd4, 6'b101100};  // Y
      8'h5a: r = '{3'd4, 6'b110000};  // Z
      8'h30: r = '{3'd5, 6'b111110};  // 0
      8'h31: r = '{3'd5, 6'b011110};  // 1
      8'h32: r = '{3'd5, 6'b001110};  // 2
      8'h33: r = '{3'd5, 6'b000110};  // 3
      8'h34: r = '{3'd5, 6'b000010};  // 4
      8'h35: r = '{3'd5, 6'b000000};  // 5
      8'h36: r = '{3'd5, 6'b100000};  // 6
      8'h37: r = '{3'd5, 6'b110000};  // 7
      8'h38: r = '{3'd5, 6'b111000};  // 8
      8'h39: r = '{3'd5, 6'b111100};  // 9
      8'h2e: r = '{3'd6, 6'b010101};  // period
      8'h2c: r = '{3'd6, 6'b110011};  // comma
      8'h3f: r = '{3'd6, 6'b001100};  // question mark
      8'h27: r = '{3'd6, 6'b011110};  // apostrophe
      8'h21: r = '{3'd6, 6'b101011};  // exclamation mark
      8'h2f: r = '{3'd5, 6'b100100};  // slash
      8'h28: r = '{3'd5, 6'b101100};  // open paren
      8'h29: r = '{3'd6, 6'b101101};  // close paren
      8'h26: r = '{3'd5, 6'b010000};  // ampersand
      8'h3a: r = '{3'd6, 6'b111000};  // colon
      8'h3b: r = '{3'd6, 6'b101010};  // semicolon
      8'h3d: r = '{3'd5, 6'b100010};  // equals
      8'h2b: r = '{3'd5, 6'b010100};  // plus
      8'h2d: r = '{3'd6, 6'b100001};  // hyphen
      8'h5f: r = '{3'd6, 6'b001101};  // underscore
      8'h22: r = '{3'd6, 6'b010010};  // double quote
      8'h40: r = '{3'd6, 6'b011010};  // at sign
      default: r = '{3'd0, 6'b000000};
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/text_to_morse_encoder.sv -----
`timescale 1ns / 1ps
// top level of the international morse code encoder
// depends on mte_pkg, mte_rom, mte_ser and assert_macros.svh
//
// input channel: one text byte per word on in_character (in_valid / in_stall).
// output channel: one symbol per word on out_symbol (0 dot, 1 dash, 2 space,
// 3 newline); out_last_of_run marks the final symbol caused by an input byte.
// a byte gives 0 to 7 symbols; lower case is folded, unknown bytes give no code
// but still owe a separator space; a newline drops the owed space.
// the first symbol of a byte is registered in the rom and then in the serializer
// buffer before it shows on the output, when the output is free.
// throughput: the output register moves one symbol per cycle while out_stall is
// low; the code rom read overlaps the draining of the previous byte, so symbols
// leave back to back.
// in_stall rises when the word behind the rom is blocked by a busy serializer.
// a stall on the output holds the current symbol and backs up to the input.
// reset clears the owed separator and empties the pipeline; no clearing pass.

module text_to_morse_encoder import mte_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_character,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SYM_W-1:0]  out_symbol,
  output logic              out_last_of_run
);

`include "assert_macros.svh"

  logic  in_fire;
  logic  owed_r, owed_nxt;
  logic  pend_vld_r, pend_vld_nxt;
  logic  pend_nl_r;
  logic  pend_owed_r;
  code_t rom_code;
  pend_t pend_word;
  logic  ser_ready;
  logic  pend_take;

  assign pend_take = pend_vld_r && ser_ready;
  assign in_stall  = pend_vld_r && !ser_ready;
  assign in_fire   = in_valid && !in_stall;

  mte_rom u_rom (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_char (in_character),
    .rd_code (rom_code)
  );

  assign pend_word = '{nl: pend_nl_r, owed: pend_owed_r, code: rom_code};

  mte_ser u_ser (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (pend_take),
    .load_word       (pend_word),
    .ready           (ser_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol      (out_symbol),
    .out_last_of_run (out_last_of_run)
  );

  always_comb begin
    owed_nxt     = owed_r;
    pend_vld_nxt = pend_vld_r;
    if (in_fire) begin
      owed_nxt     = (in_character != CHAR_NEWLINE);
      pend_vld_nxt = 1'b1;
    end else if (pend_take) begin
      pend_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r     <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      owed_r     <= owed_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  // side info travels with the rom read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_nl_r   <= (in_character == CHAR_NEWLINE);
      pend_owed_r <= owed_r;
    end
  end

  `MTE_ASSERT_IMP(a_newline_ends_run, out_valid && out_symbol == SYM_NEWLINE, out_last_of_run)
  `MTE_ASSERT_NXT(a_newline_clears_owed, in_fire && in_character == CHAR_NEWLINE, !owed_r)
  `MTE_ASSERT_NXT(a_word_waits_after_accept, in_fire, pend_vld_r)
  `MTE_ASSERT_IMP(a_take_only_when_free, pend_take, !out_valid || (out_last_of_run && !out_stall))

endmodule

// ----- hdl/mte_rom.sv -----
`timescale 1ns / 1ps
// morse code rom with a registered read, folds lower case on the address
// depends on mte_pkg

module mte_rom import mte_pkg::*; (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [CHAR_W-1:0] rd_char,
  output code_t             rd_code
);

  logic [CHAR_W-1:0] addr;
  code_t             code_r;

  always_comb begin
    if (rd_char >= CHAR_LOWER_A && rd_char <= CHAR_LOWER_Z) begin
      addr = rd_char - CASE_OFFSET;
    end else begin
      addr = rd_char;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      code_r <= code_lookup(addr);
    end
  end

  assign rd_code = code_r;

endmodule

// ----- hdl/mte_ser.sv -----
`timescale 1ns / 1ps
// symbol serializer and output register of the morse encoder
// depends on mte_pkg

module mte_ser import mte_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  pend_t            load_word,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SYM_W-1:0] out_symbol,
  output logic             out_last_of_run
);

  logic [BUF_W-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BUF_W-SYM_W-1:0] code_syms;
  logic [BUF_W-1:0] load_buf;
  logic [CNT_W-1:0] load_cnt;
  logic             out_fire;

  assign out_fire  = out_valid && !out_stall;
  // free now, or the last symbol leaves this cycle
  assign ready     = (cnt_r == '0) || (cnt_r == CNT_W'(1) && !out_stall);

  always_comb begin
    for (int k = 0; k < PAT_W; k++) begin
      if (LEN_W'(k) < load_word.code.len) begin
        code_syms[SYM_W*k +: SYM_W] = load_word.code.pat[PAT_W-1-k] ? SYM_DASH : SYM_DOT;
      end else begin
        code_syms[SYM_W*k +: SYM_W] = SYM_DOT;
      end
    end
    if (load_word.nl) begin
      load_buf = {{(BUF_W-SYM_W){1'b0}}, SYM_NEWLINE};
      load_cnt = CNT_W'(1);
    end else if (load_word.owed) begin
      load_buf = {code_syms, SYM_SPACE};
      load_cnt = CNT_W'(load_word.code.len) + CNT_W'(1);
    end else begin
      load_buf = {{SYM_W{1'b0}}, code_syms};
      load_cnt = CNT_W'(load_word.code.len);
    end
  end

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (load) begin
      buf_nxt = load_buf;
      cnt_nxt = load_cnt;
    end else if (out_fire) begin
      buf_nxt = {{SYM_W{1'b0}}, buf_r[BUF_W-1:SYM_W]};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  assign out_valid       = (cnt_r != '0);
  assign out_symbol      = buf_r[SYM_W-1:0];
  assign out_last_of_run = (cnt_r == CNT_W'(1));

endmodule

// ----- dv/morse_checker.sv -----
`timescale 1ns / 1ps
// scoreboard for the morse encoder: predicts the symbols of every accepted text
// word and checks them in order against the output channel; depends on mte_pkg

module morse_checker import mte_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [CHAR_W-1:0] in_character,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [SYM_W-1:0]  out_symbol,
  input  logic              out_last_of_run,
  output int                mismatches,
  output int                pending
);

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
  } morse_sym_t;

  morse_sym_t expected_syms[$];
  morse_sym_t want;
  logic       space_owed = 1'b0;

  function automatic string morse_code(input logic [CHAR_W-1:0] ch);
    case (ch)
      "A": return ".-";
      "B": return "-...";
      "C": return "-.-.";
      "D": return "-..";
      "E": return ".";
      "F": return "..-.";
      "G": return "--.";
      "H": return "....";
      "I": return "..";
      "J": return ".---";
      "K": return "-.-";
      "L": return ".-..";
      "M": return "--";
      "N": return "-.";
      "O": return "---";
      "P": return ".--.";
      "Q": return "--.-";
      "R": return ".-.";
      "S": return "...";
      "T": return "-";
      "U": return "..-";
      "V": return "...-";
      "W": return ".--";
      "X": return "-..-";
      "Y": return "-.--";
      "Z": return "--..";
      "0": return "-----";
      "1": return ".----";
      "2": return "..---";
      "3": return "...--";
      "4": return "....-";
      "5": return ".....";
      "6": return "-....";
      "7": return "--...";
      "8": return "---..";
      "9": return "----.";
      ".": return ".-.-.-";
      ",": return "--..--";
      "?": return "..--..";
      8'd39: return ".----.";
      "!": return "-.-.--";
      "/": return "-..-.";
      "(": return "-.--.";
      ")": return "-.--.-";
      "&": return ".-...";
      ":": return "---...";
      ";": return "-.-.-.";
      "=": return "-...-";
      "+": return ".-.-.";
      "-": return "-....-";
      "_": return "..--.-";
      8'h22: return ".-..-.";
      "@": return ".--.-.";
      default: return "";
    endcase
  endfunction

  function automatic void predict_symbols(input logic [CHAR_W-1:0] ch);
    logic [SYM_W-1:0]  run[$];
    logic [CHAR_W-1:0] key;
    string             code;
    key = ch;
    if (ch == CHAR_NEWLINE) begin
      // an owed space is simply dropped at the end of a line
      space_owed = 1'b0;
      run.push_back(SYM_NEWLINE);
    end else begin
      if (key >= "a" && key <= "z") key = key - CASE_OFFSET;
      if (space_owed) run.push_back(SYM_SPACE);
      // space and unknown bytes have no code but still owe a separator
      code = morse_code(key);
      for (int k = 0; k < code.len(); k++)
        run.push_back((code[k] == "-") ? SYM_DASH : SYM_DOT);
      space_owed = 1'b1;
    end
    foreach (run[k]) expected_syms.push_back('{run[k], k == run.size() - 1});
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_syms.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: symbol %0d last %0b arrived with nothing expected",
                     $time, out_symbol, out_last_of_run);
          mismatches = mismatches + 1;
        end else begin
          want = expected_syms.pop_front();
          if (want.sym !== out_symbol || want.last !== out_last_of_run) begin
            if (mismatches < 10)
              $display("%0t: expected symbol %0d last %0b, got symbol %0d last %0b",
                       $time, want.sym, want.last, out_symbol, out_last_of_run);
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall) predict_symbols(in_character);
      pending <= expected_syms.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// top of the morse encoder testbench: clock, reset, text stimulus, output stalls
// and verdict; depends on mte_pkg, text_to_morse_encoder and morse_checker

module tb import mte_pkg::*; ();

  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic [CHAR_W-1:0] in_character = '0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [SYM_W-1:0]  out_symbol;
  logic              out_last_of_run;

  int    mismatches;
  int    pending;
  int    idle_cycles = 0;
  bit    hold_req = 1'b0;
  string text_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.,?'!/()&:;=+-_\"@";
  logic [CHAR_W-1:0] opening [0:23];

  text_to_morse_encoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_character    (in_character),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol      (out_symbol),
    .out_last_of_run (out_last_of_run)
  );

  morse_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_character    (in_character),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol      (out_symbol),
    .out_last_of_run (out_last_of_run),
    .mismatches      (mismatches),
    .pending         (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly table characters, some spaces and line ends, the rest any byte
  function automatic logic [CHAR_W-1:0] pick_text();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return text_set[$urandom_range(0, text_set.len() - 1)];
    if (r < 70) return 8'h20;
    if (r < 80) return CHAR_NEWLINE;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic send_word(input logic [CHAR_W-1:0] ch, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    bit busy;
    busy = 1'b0;
    for (int n = 0; n < count; n++) begin
      // now and then a stretch of back-to-back words
      if (n % 20 == 0) busy = ($urandom_range(0, 3) == 0);
      send_word(pick_text(), busy ? 0 : gap_cycles());
    end
  endtask

  // output side: alternating free and stalled runs, plus one long hold-off
  initial begin
    int run_left;
    bit run_stalled;
    run_left    = 0;
    run_stalled = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_stalled = !run_stalled;
          if (run_stalled)
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
          else
            run_left = $urandom_range(1, 30);
        end
        run_left--;
        out_stall <= run_stalled;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // empty line, case folding, longest codes, line end after a character,
    // double space, unknown bytes and the edges of the lower-case range
    opening = '{CHAR_NEWLINE, "A", "z", "m", "0", "9", ".", 8'd39,
                "@", ")", CHAR_NEWLINE, " ", " ", "#", 8'h00, 8'h80,
                8'hff, 8'h60, 8'h7b, "E", CHAR_NEWLINE, CHAR_NEWLINE, 8'h22, "Q"};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (opening[i]) send_word(opening[i], gap_cycles());
    wait_drained();
    send_random(80);
    // long output hold-off while words keep coming, so the input backs up
    hold_req = 1'b1;
    for (int n = 0; n < 30; n++) send_word(pick_text(), 0);
    wait_drained();
    send_random(80);
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
